/* rtl/core/tmbg_pkg.sv */
// Shared widths, register indexes and scaling constants of the battery gauge.
package tmbg_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int GAIN_W    = 12;
	localparam int OFFSET_W  = 24;
	localparam int PCT_W     = 7;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 24;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(660);
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1310400);

	// numerator = gain * average - offset, two's complement
	localparam int PRODUCT_W = GAIN_W + SAMPLE_W;
	localparam int NUM_W     = PRODUCT_W + 1;

	// percent = floor(n / 4095) for 0 < n < 409500, by reciprocal multiply
	localparam int    FULL_SCALE_NUM = 409500;
	localparam int    CODE_SPAN      = 4095;
	localparam int    PCT_PCT_MAX    = 100;
	localparam int    PCT_NUM_W      = 19;
	localparam int    PCT_SHIFT      = PCT_NUM_W + 12 + 1;
	localparam longint PCT_RECIP     = ((longint'(1) << PCT_SHIFT) + CODE_SPAN - 1) / CODE_SPAN;
	localparam int    PCT_RECIP_W    = 21;
	localparam int    PCT_PROD_W     = PCT_NUM_W + PCT_RECIP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERCENT_GAIN   = CFG_IDX_W'(0),
		REG_PERCENT_OFFSET = CFG_IDX_W'(1)
	} cfg_reg_t;

endpackage

/* rtl/core/trimmed_mean_battery_gauge.sv */
// Top level of the trimmed-mean battery gauge.
// Takes one 12-bit sample per cycle. Every SAMPLE_COUNT samples it drops the
// minimum and maximum, averages the rest and maps the average to a 0..100
// percentage. After the burst's last sample the result passes through registers for
// the trimmed sum, reciprocal divide, gain/offset, and percent divide and clamp. The
// input stalls only on a burst's last sample while the result pipeline is full
// behind a held output.
module trimmed_mean_battery_gauge import tmbg_pkg::*; #(
	parameter int SAMPLE_COUNT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] adc_sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [11:0] average_code, [18:12] battery_percent
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int     SUM_W      = SAMPLE_W + $clog2(SAMPLE_COUNT);
	localparam longint DIV        = longint'(SAMPLE_COUNT - 2);
	localparam int     DIV_SHIFT  = SUM_W + $clog2(SAMPLE_COUNT - 2) + 1;
	localparam longint DIV_RECIP  = ((longint'(1) << DIV_SHIFT) + DIV - 1) / DIV;
	localparam int     RECIP_W    = $clog2(DIV_RECIP + 1);
	localparam int     DPROD_W    = SUM_W + RECIP_W;

	logic [GAIN_W-1:0]   gain_q;
	logic [OFFSET_W-1:0] offset_q;

	logic                take;
	logic                at_last;
	logic [SUM_W-1:0]    trimmed;

	logic                v_s1, v_s2, v_s3, v_q;
	logic                free1, free2, free3, free_out;
	logic [SUM_W-1:0]    trim_s1;
	logic [SAMPLE_W-1:0] avg_s2, avg_s3, avg_q;
	logic [NUM_W-1:0]    num_s3;
	logic [PCT_W-1:0]    pct_q;

	logic [DPROD_W-1:0]    div_prod;
	logic [PRODUCT_W-1:0]  gain_prod;
	logic [NUM_W-1:0]      num_n;
	logic [PCT_PROD_W-1:0] pct_prod;
	logic                  num_low;
	logic                  num_full;
	logic [PCT_W-1:0]      pct_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERCENT_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_PERCENT_OFFSET: offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign free_out = !v_q || m_tready;
	assign free3    = !v_s3 || free_out;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;

	assign s_tready = !at_last || free1;
	assign take     = s_tvalid && s_tready;

	tmbg_accum #(
		.SAMPLE_COUNT(SAMPLE_COUNT)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.sample  (s_tdata[SAMPLE_W-1:0]),
		.at_last (at_last),
		.trimmed (trimmed)
	);

	assign div_prod  = DPROD_W'(trim_s1) * DPROD_W'(DIV_RECIP);
	assign gain_prod = PRODUCT_W'(gain_q) * PRODUCT_W'(avg_s2);
	assign num_n     = NUM_W'(gain_prod) - NUM_W'(offset_q);

	assign num_low  = num_s3[NUM_W-1] || (num_s3 == '0);
	assign num_full = !num_s3[NUM_W-1] && (num_s3 >= NUM_W'(FULL_SCALE_NUM));
	assign pct_prod = PCT_PROD_W'(num_s3[PCT_NUM_W-1:0]) * PCT_PROD_W'(PCT_RECIP);

	always_comb begin
		priority if (num_low) begin
			pct_n = '0;
		end else if (num_full) begin
			pct_n = PCT_W'(PCT_PCT_MAX);
		end else begin
			pct_n = pct_prod[PCT_SHIFT +: PCT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (free1)    v_s1 <= take && at_last;
			if (free2)    v_s2 <= v_s1;
			if (free3)    v_s3 <= v_s2;
			if (free_out) v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (free1) begin
			trim_s1 <= trimmed;
		end
		if (free2) begin
			avg_s2 <= div_prod[DIV_SHIFT +: SAMPLE_W];
		end
		if (free3) begin
			avg_s3 <= avg_s2;
			num_s3 <= num_n;
		end
		if (free_out) begin
			avg_q <= avg_s3;
			pct_q <= pct_n;
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = {(M_TDATA_W - SAMPLE_W - PCT_W)'(0), pct_q, avg_q};

`ifndef ASSERT_OFF
	a_stall_only_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> at_last && v_s1 && v_s2 && v_s3 && v_q && !m_tready)
		else $error("input stalled without a full result pipeline");

	a_s1_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(take && at_last))
		else $error("result started without a burst's last sample");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> pct_q <= PCT_W'(PCT_PCT_MAX))
		else $error("battery percentage above full scale");
`endif

endmodule

/* rtl/core/tmbg_accum.sv */
// Burst accumulator: running sum, minimum, maximum and trimmed sum of a burst.
module tmbg_accum import tmbg_pkg::*; #(
	parameter int SAMPLE_COUNT = 32,
	localparam int SUM_W = SAMPLE_W + $clog2(SAMPLE_COUNT),
	localparam int IDX_W = $clog2(SAMPLE_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                at_last,
	output logic [SUM_W-1:0]    trimmed
);

	logic [IDX_W-1:0]    idx_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;

	logic [SUM_W-1:0]    sum_n;
	logic [SAMPLE_W-1:0] min_n;
	logic [SAMPLE_W-1:0] max_n;

	assign at_last = (idx_q == IDX_W'(SAMPLE_COUNT - 1));
	assign sum_n   = sum_q + SUM_W'(sample);
	assign min_n   = (sample < min_q) ? sample : min_q;
	assign max_n   = (sample > max_q) ? sample : max_q;
	assign trimmed = sum_n - SUM_W'(min_n) - SUM_W'(max_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else if (take) begin
			if (at_last) begin
				idx_q <= '0;
				sum_q <= '0;
				min_q <= '1;
				max_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				sum_q <= sum_n;
				min_q <= min_n;
				max_q <= max_n;
			end
		end
	end

`ifndef ASSERT_OFF
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> min_q <= max_q)
		else $error("running minimum above running maximum inside a burst");

	a_burst_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && at_last |=> idx_q == '0 && sum_q == '0 && max_q == '0)
		else $error("accumulators not cleared after the last sample of a burst");
`endif

endmodule

/* bench/trimmed_mean_battery_gauge_test.sv */
// Self-checking bench for the trimmed-mean battery gauge: bursts of samples, predicted readings.
module trimmed_mean_battery_gauge_test;
	import tmbg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_COUNT = 32;
	localparam int SETTLE_CYCLES = 12;
	localparam longint FULL_NUMERATOR = 409500;
	localparam longint VOLT_SPAN = 4095;
	localparam logic [PCT_W-1:0] PERCENT_FULL = PCT_W'(100);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average_code;
		logic [PCT_W-1:0]    battery_percent;
	} gauge_reading_t;

	typedef enum int {SHAPE_NOISE, SHAPE_FLAT, SHAPE_CLUSTER} burst_shape_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;    // [11:0] adc_sample
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;         // [11:0] average_code, [18:12] battery_percent
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [GAIN_W-1:0]   scale_gain;
	logic [OFFSET_W-1:0] scale_offset;
	int unsigned         burst_fill;
	int unsigned         burst_sum;
	logic [SAMPLE_W-1:0] burst_lo;
	logic [SAMPLE_W-1:0] burst_hi;

	gauge_reading_t      pending_readings[$];
	logic [SAMPLE_W-1:0] burst_codes[SAMPLE_COUNT];
	int unsigned         src_gap_pct = 8;
	int unsigned         sink_stall_pct = 49;
	int unsigned         mismatch_count = 0;

	trimmed_mean_battery_gauge #(
		.SAMPLE_COUNT(SAMPLE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic gauge_reading_t trimmed_reading(input int unsigned sum,
			input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
		gauge_reading_t r;
		int unsigned    trimmed;
		longint         numerator;
		trimmed = sum - lo - hi;
		r.average_code = SAMPLE_W'(trimmed / (SAMPLE_COUNT - 2));
		numerator = longint'(scale_gain) * longint'(r.average_code) - longint'(scale_offset);
		if (numerator <= 0)
			r.battery_percent = '0;
		else if (numerator >= FULL_NUMERATOR)
			r.battery_percent = PERCENT_FULL;
		else
			r.battery_percent = PCT_W'(numerator / VOLT_SPAN);
		return r;
	endfunction

	task automatic clear_burst();
		burst_fill = 0;
		burst_sum = 0;
		burst_lo = '1;
		burst_hi = '0;
	endtask

	task automatic accumulate_sample(input logic [SAMPLE_W-1:0] code);
		burst_sum += code;
		if (code < burst_lo)
			burst_lo = code;
		if (code > burst_hi)
			burst_hi = code;
		burst_fill++;
		if (burst_fill == SAMPLE_COUNT) begin
			pending_readings.push_back(trimmed_reading(burst_sum, burst_lo, burst_hi));
			clear_burst();
		end
	endtask

	task automatic log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// valid stays high after a transfer; the next call or drain_and_settle decides
	task automatic send_sample(input logic [SAMPLE_W-1:0] code);
		while ($urandom_range(99, 0) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(code);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		accumulate_sample(code);
	endtask

	task automatic send_burst();
		for (int i = 0; i < SAMPLE_COUNT; i++)
			send_sample(burst_codes[i]);
	endtask

	task automatic send_flat_burst(input logic [SAMPLE_W-1:0] code);
		for (int i = 0; i < SAMPLE_COUNT; i++)
			burst_codes[i] = code;
		send_burst();
	endtask

	task automatic send_random_burst();
		burst_shape_t shape;
		int           pick;
		int           center;
		int           spread;
		int           v;
		pick = $urandom_range(9, 0);
		shape = (pick == 0) ? SHAPE_NOISE : (pick == 1) ? SHAPE_FLAT : SHAPE_CLUSTER;
		center = $urandom_range(1, 0) ? $urandom_range(2700, 1900) : $urandom_range(4095, 0);
		spread = $urandom_range(63, 0);
		for (int i = 0; i < SAMPLE_COUNT; i++) begin
			if (shape == SHAPE_NOISE || $urandom_range(15, 0) == 0)
				v = $urandom_range(4095, 0);
			else if (shape == SHAPE_FLAT)
				v = center;
			else begin
				v = center - spread + $urandom_range(2 * spread, 0);
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end
			burst_codes[i] = SAMPLE_W'(v);
		end
		send_burst();
	endtask

	// called right after a sample transfer or after a previous drain
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// valid stays high after a transfer; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_PERCENT_GAIN:   scale_gain = val[GAIN_W-1:0];
			REG_PERCENT_OFFSET: scale_offset = val[OFFSET_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_scale(input logic [GAIN_W-1:0] gain, input logic [OFFSET_W-1:0] offset);
		drain_and_settle();
		write_reg(REG_PERCENT_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_PERCENT_OFFSET, offset);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_scale();
		send_flat_burst(SAMPLE_W'(2300));
		for (int i = 0; i < SAMPLE_COUNT; i++)
			burst_codes[i] = SAMPLE_W'(1990 + 20 * i);
		send_burst();
	endtask

	task automatic test_code_extremes();
		send_flat_burst('0);
		send_flat_burst('1);
		// lone outliers at both ends are trimmed away
		for (int i = 0; i < SAMPLE_COUNT; i++)
			burst_codes[i] = SAMPLE_W'(2500);
		burst_codes[3] = '0;
		burst_codes[17] = '1;
		send_burst();
		// duplicated minimum: only one copy is dropped
		for (int i = 0; i < SAMPLE_COUNT; i++)
			burst_codes[i] = SAMPLE_W'(2400);
		burst_codes[0] = SAMPLE_W'(1000);
		burst_codes[SAMPLE_COUNT-1] = SAMPLE_W'(1000);
		send_burst();
	endtask

	task automatic test_percent_boundaries();
		// gain 200, mean 3000: numerator 600000 - offset
		int unsigned offsets[6] = '{190500, 190501, 595905, 595906, 600000, 700000};
		for (int i = 0; i < 6; i++) begin
			set_scale(GAIN_W'(200), OFFSET_W'(offsets[i]));
			send_flat_burst(SAMPLE_W'(3000));
		end
	endtask

	task automatic test_register_writes();
		drain_and_settle();
		write_reg(REG_SPARE, CFG_DATA_W'(24'h123456));
		write_reg(REG_TOP, '1);
		write_reg(REG_PERCENT_GAIN, CFG_DATA_W'(24'h5A32B4));
		write_reg(REG_PERCENT_OFFSET, CFG_DATA_W'(1400000));
		cfg_valid <= 1'b0;
		send_random_burst();
		send_flat_burst(SAMPLE_W'(2600));
	endtask

	task automatic test_register_extremes();
		set_scale('0, '0);
		send_random_burst();
		set_scale('1, '0);
		send_random_burst();
		send_flat_burst(SAMPLE_W'(100));
		set_scale('1, '1);
		send_flat_burst('1);
		set_scale('0, '1);
		send_random_burst();
		set_scale(GAIN_RESET, OFFSET_RESET);
		send_random_burst();
	endtask

	task automatic test_random_traffic();
		int unsigned gain;
		int unsigned empty_code;
		for (int phase = 0; phase < 3; phase++) begin
			src_gap_pct = (phase == 0) ? 8 : (phase == 1) ? 49 : 0;
			sink_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 8 : 0;
			gain = $urandom_range(900, 500);
			empty_code = $urandom_range(2500, 1500);
			set_scale(GAIN_W'(gain), OFFSET_W'(gain * empty_code));
			for (int b = 0; b < 3; b++)
				send_random_burst();
		end
	endtask

	always @(posedge clk) begin
		gauge_reading_t want;
		logic [SAMPLE_W-1:0] got_avg;
		logic [PCT_W-1:0]    got_pct;
		if (arst_n && m_tvalid && m_tready) begin
			got_avg = m_tdata[SAMPLE_W-1:0];
			got_pct = m_tdata[SAMPLE_W +: PCT_W];
			if (pending_readings.size() == 0)
				log_failure($sformatf("unexpected reading: average_code %0d battery_percent %0d",
					got_avg, got_pct));
			else begin
				want = pending_readings.pop_front();
				if (got_avg !== want.average_code)
					log_failure($sformatf("average_code expected %0d, got %0d",
						want.average_code, got_avg));
				if (got_pct !== want.battery_percent)
					log_failure($sformatf("battery_percent expected %0d, got %0d",
						want.battery_percent, got_pct));
			end
		end
		m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	initial begin
		scale_gain = GAIN_RESET;
		scale_offset = OFFSET_RESET;
		clear_burst();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_scale();
		test_code_extremes();
		test_percent_boundaries();
		test_register_writes();
		test_register_extremes();
		test_random_traffic();
		drain_and_settle();
		if (pending_readings.size() != 0)
			log_failure("readings still pending at end of run");
		if (mismatch_count == 0)
			$display("trimmed_mean_battery_gauge_test: clean");
		else
			$display("trimmed_mean_battery_gauge_test: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("trimmed_mean_battery_gauge_test: errors");
		$finish;
	end

endmodule
